// File: rtl/core/frd_pkg.sv
// ============================================================================
// frd_pkg
// Shared types and constants of the frame rate drop/repeat converter.
// ============================================================================
package frd_pkg;

    localparam int SRC_W      = 18;
    localparam int TGT_W      = 19;
    localparam int PREC_W     = 27;
    localparam int RATIO_W    = 45;
    localparam int TAG_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 27;

    // Depth of the request queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    localparam logic [SRC_W-1:0]  SRC_RESET  = 18'd25000;
    localparam logic [TGT_W-1:0]  TGT_RESET  = 19'd25000;
    localparam logic [PREC_W-1:0] PREC_RESET = 27'd1000;

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;
    localparam cfg_index_t REG_SOURCE_RATE = 2'd0;
    localparam cfg_index_t REG_TARGET_RATE = 2'd1;
    localparam cfg_index_t REG_PRECISION   = 2'd2;

    typedef logic [1:0] mode_t;
    localparam mode_t MODE_PASS   = 2'd0;
    localparam mode_t MODE_DROP   = 2'd1;
    localparam mode_t MODE_REPEAT = 2'd2;

    // Values precomputed by the setup unit for the front end.
    typedef struct packed {
        logic                busy;
        mode_t               mode;
        logic [RATIO_W-1:0]  ratio;
        logic [RATIO_W-1:0]  inc_new;
        logic [RATIO_W-1:0]  inc_lat;
        logic [PREC_W-1:0]   prec;
    } setup_status_t;

endpackage

// File: rtl/core/frame_rate_drop_repeat.sv
// ============================================================================
// frame_rate_drop_repeat
// An accepted request is written into the queue and then loaded into the
// output register once that register is free. The front takes one request
// per cycle while full is low; a repeated frame holds the output register
// for both of its results. Reset and every register write start a setup
// pass, a multiply and then up to three divisions, with full high.
// ============================================================================
module frame_rate_drop_repeat
    import frd_pkg::*;
#(
    parameter int INDEX_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration write port.
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    // Source frame requests.
    input  logic                   push,
    output logic                   full,
    input  logic [TAG_W-1:0]       frame_tag,
    input  logic                   final_frame,
    // Output frame results.
    output logic                   empty,
    input  logic                   pop,
    output logic [INDEX_WIDTH-1:0] source_index,
    output logic [INDEX_WIDTH-1:0] output_index,
    output logic [TAG_W-1:0]       tag_out,
    output logic                   run_last,
    output logic                   stream_end
);

    // A queued request carries the source number, the first output number,
    // the tag, the end-of-stream flag and a repeat flag.
    localparam int ENTRY_W = 2 * INDEX_WIDTH + TAG_W + 2;

    setup_status_t      status;
    logic [RATIO_W-1:0] ratio_lat;
    logic               latch;
    logic               q_push;
    logic [ENTRY_W-1:0] q_wdata;
    logic               q_full;
    logic               q_pop;
    logic [ENTRY_W-1:0] q_rdata;
    logic               q_empty;

    // The setup unit holds the registers and, whenever they change, works out
    // the step ratio, the mode and the phase increment for the next stream.
    // It also refreshes the increment against the ratio in use, since the
    // precision may change between frames of a running stream.
    frd_setup u_setup (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .ratio_lat (ratio_lat),
        .latch     (latch),
        .status    (status)
    );

    // The front end latches the ratio at the first frame of a stream, keeps
    // the phase remainder and decides how many results each frame gives.
    // Dropped frames never enter the queue.
    frd_front #(
        .INDEX_WIDTH (INDEX_WIDTH),
        .ENTRY_W     (ENTRY_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .frame_tag   (frame_tag),
        .final_frame (final_frame),
        .full        (full),
        .status      (status),
        .ratio_lat   (ratio_lat),
        .latch       (latch),
        .q_push      (q_push),
        .q_data      (q_wdata),
        .q_full      (q_full)
    );

    frd_fifo #(
        .WIDTH (ENTRY_W)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wdata),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rdata),
        .empty   (q_empty)
    );

    // The back end expands a repeated frame into two results with
    // consecutive output numbers; the output register lets the front keep
    // accepting while a result waits to be taken.
    frd_back #(
        .INDEX_WIDTH (INDEX_WIDTH),
        .ENTRY_W     (ENTRY_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_data       (q_rdata),
        .q_pop        (q_pop),
        .empty        (empty),
        .pop          (pop),
        .source_index (source_index),
        .output_index (output_index),
        .tag_out      (tag_out),
        .run_last     (run_last),
        .stream_end   (stream_end)
    );

endmodule

// File: rtl/core/frd_div.sv
// ============================================================================
// frd_div
// Restoring divider, one quotient bit per cycle, with quotient and remainder.
// ============================================================================
module frd_div
    import frd_pkg::*;
#(
    parameter int W = 45
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quot,
    output logic [W-1:0] rem
);

    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     rem_reg;
    logic [W-1:0]     dq_reg;
    logic [W-1:0]     dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [W:0] trial;
    logic [W:0] diff;
    logic       ge;

    assign trial = {rem_reg, dq_reg[W-1]};
    assign ge    = trial >= {1'b0, dvs_reg};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dq_reg  <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[W-1:0] : trial[W-1:0];
            dq_reg  <= {dq_reg[W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = dq_reg;
    assign rem  = rem_reg;

endmodule

// File: rtl/core/frd_setup.sv
// ============================================================================
// frd_setup
// Configuration registers and the sequencer that precomputes the step ratio,
// the new mode and the per-frame phase increments with a shared divider.
// ============================================================================
module frd_setup
    import frd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [RATIO_W-1:0]    ratio_lat,
    input  logic                  latch,
    output setup_status_t         status
);

    localparam logic [2:0] ST_IDLE       = 3'd0;
    localparam logic [2:0] ST_MUL        = 3'd1;
    localparam logic [2:0] ST_RATIO_GO   = 3'd2;
    localparam logic [2:0] ST_RATIO_WAIT = 3'd3;
    localparam logic [2:0] ST_MODN_GO    = 3'd4;
    localparam logic [2:0] ST_MODN_WAIT  = 3'd5;
    localparam logic [2:0] ST_MODL_GO    = 3'd6;
    localparam logic [2:0] ST_MODL_WAIT  = 3'd7;

    logic [SRC_W-1:0]   src_reg;
    logic [TGT_W-1:0]   tgt_reg;
    logic [PREC_W-1:0]  prec_reg;
    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    logic [RATIO_W-1:0] prod_reg;
    logic [RATIO_W-1:0] ratio_reg;
    mode_t              mode_reg;
    logic [RATIO_W-1:0] inc_new_reg;
    logic [RATIO_W-1:0] inc_lat_reg;

    logic [TGT_W-1:0]   src_ext;
    logic [TGT_W-1:0]   diff;
    logic [RATIO_W-1:0] prod;
    logic               div_start;
    logic [RATIO_W-1:0] div_dividend;
    logic [RATIO_W-1:0] div_divisor;
    logic               div_done;
    logic [RATIO_W-1:0] div_quot;
    logic [RATIO_W-1:0] div_rem;

    assign src_ext = {1'b0, src_reg};
    assign diff    = (tgt_reg > src_ext) ? (tgt_reg - src_ext) : (src_ext - tgt_reg);
    assign prod    = RATIO_W'(src_reg) * RATIO_W'(prec_reg);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg  <= SRC_RESET;
            tgt_reg  <= TGT_RESET;
            prec_reg <= PREC_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SOURCE_RATE: src_reg  <= cfg_wdata[SRC_W-1:0];
                REG_TARGET_RATE: tgt_reg  <= cfg_wdata[TGT_W-1:0];
                REG_PRECISION:   prec_reg <= cfg_wdata[PREC_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        div_start    = 1'b0;
        div_dividend = RATIO_W'(prec_reg);
        div_divisor  = ratio_reg;
        unique case (state_reg)
            ST_IDLE:       state_next = ST_IDLE;
            ST_MUL:        state_next = ST_RATIO_GO;
            ST_RATIO_GO:
            begin
                div_dividend = prod_reg;
                div_divisor  = RATIO_W'(diff);
                div_start    = (diff != '0);
                state_next   = (diff != '0) ? ST_RATIO_WAIT : ST_MODN_GO;
            end
            ST_RATIO_WAIT: state_next = div_done ? ST_MODN_GO : ST_RATIO_WAIT;
            ST_MODN_GO:
            begin
                div_start  = (ratio_reg != '0);
                state_next = (ratio_reg != '0) ? ST_MODN_WAIT : ST_MODL_GO;
            end
            ST_MODN_WAIT:  state_next = div_done ? ST_MODL_GO : ST_MODN_WAIT;
            ST_MODL_GO:
            begin
                div_divisor = ratio_lat;
                div_start   = (ratio_lat != '0);
                state_next  = (ratio_lat != '0) ? ST_MODL_WAIT : ST_IDLE;
            end
            ST_MODL_WAIT:  state_next = div_done ? ST_IDLE : ST_MODL_WAIT;
            default:       state_next = ST_IDLE;
        endcase
        // Any register write starts the computation over.
        if (cfg_we)
        begin
            state_next = ST_MUL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_MUL;
            ratio_reg   <= '0;
            mode_reg    <= MODE_PASS;
            inc_new_reg <= '0;
            inc_lat_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (latch)
            begin
                inc_lat_reg <= inc_new_reg;
            end
            unique case (state_reg)
                ST_RATIO_GO:
                begin
                    if (diff == '0)
                    begin
                        ratio_reg <= '0;
                        mode_reg  <= MODE_PASS;
                    end
                end
                ST_RATIO_WAIT:
                begin
                    if (div_done)
                    begin
                        ratio_reg <= div_quot;
                        if (div_quot == '0)
                        begin
                            mode_reg <= MODE_PASS;
                        end
                        else
                        begin
                            mode_reg <= (tgt_reg < src_ext) ? MODE_DROP : MODE_REPEAT;
                        end
                    end
                end
                ST_MODN_GO:
                begin
                    if (ratio_reg == '0)
                    begin
                        inc_new_reg <= '0;
                    end
                end
                ST_MODN_WAIT:
                begin
                    if (div_done)
                    begin
                        inc_new_reg <= div_rem;
                    end
                end
                ST_MODL_GO:
                begin
                    if (ratio_lat == '0)
                    begin
                        inc_lat_reg <= '0;
                    end
                end
                ST_MODL_WAIT:
                begin
                    if (div_done)
                    begin
                        inc_lat_reg <= div_rem;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MUL)
        begin
            prod_reg <= prod;
        end
    end

    frd_div #(
        .W (RATIO_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    assign status.busy    = (state_reg != ST_IDLE);
    assign status.mode    = mode_reg;
    assign status.ratio   = ratio_reg;
    assign status.inc_new = inc_new_reg;
    assign status.inc_lat = inc_lat_reg;
    assign status.prec    = prec_reg;

endmodule

// File: rtl/core/frd_front.sv
// ============================================================================
// frd_front
// Accepts source frame requests, tracks the phase and classifies each frame
// as dropped, passed once or repeated.
// ============================================================================
module frd_front
    import frd_pkg::*;
#(
    parameter int INDEX_WIDTH = 32,
    parameter int ENTRY_W     = 2 * INDEX_WIDTH + TAG_W + 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [TAG_W-1:0]   frame_tag,
    input  logic               final_frame,
    output logic               full,
    input  setup_status_t      status,
    output logic [RATIO_W-1:0] ratio_lat,
    output logic               latch,
    output logic               q_push,
    output logic [ENTRY_W-1:0] q_data,
    input  logic               q_full
);

    logic [INDEX_WIDTH-1:0] src_cnt_reg;
    logic [INDEX_WIDTH-1:0] out_cnt_reg;
    logic [RATIO_W-1:0]     phase_reg;
    logic [RATIO_W-1:0]     ratio_reg;
    mode_t                  mode_reg;

    logic               accept;
    logic               first;
    logic [RATIO_W-1:0] ratio_use;
    mode_t              mode_use;
    logic [RATIO_W-1:0] inc_use;
    logic [RATIO_W-1:0] r_use;
    logic [RATIO_W-1:0] gap;
    logic               active;
    logic               marked;
    logic [RATIO_W:0]   sum;
    logic [RATIO_W:0]   sum_sub;
    logic [RATIO_W-1:0] phase_adv;
    logic               drop_it;
    logic               rep;

    assign full   = status.busy || q_full;
    assign accept = push && !full;
    assign first  = (src_cnt_reg == '0);

    // The first frame of a stream takes the freshly computed ratio and mode.
    assign ratio_use = first ? status.ratio : ratio_reg;
    assign mode_use  = first ? status.mode : mode_reg;
    assign inc_use   = first ? status.inc_new : status.inc_lat;
    assign r_use     = first ? '0 : phase_reg;

    assign gap    = ratio_use - r_use;
    assign active = (mode_use != MODE_PASS) && (ratio_use != '0);
    assign marked = active && (status.prec != '0)
                    && ((r_use == '0) || (gap < RATIO_W'(status.prec)));

    // Both terms are below the ratio, so one conditional subtract wraps it.
    assign sum       = {1'b0, r_use} + {1'b0, inc_use};
    assign sum_sub   = sum - {1'b0, ratio_use};
    assign phase_adv = (sum >= {1'b0, ratio_use}) ? sum_sub[RATIO_W-1:0]
                                                  : sum[RATIO_W-1:0];

    assign drop_it = (mode_use == MODE_DROP) && marked;
    assign rep     = (mode_use == MODE_REPEAT) && marked;

    assign q_push    = accept && !drop_it;
    assign q_data    = {src_cnt_reg, out_cnt_reg, frame_tag, final_frame, rep};
    assign latch     = accept && first;
    assign ratio_lat = ratio_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_cnt_reg <= '0;
            out_cnt_reg <= '0;
            phase_reg   <= '0;
            ratio_reg   <= '0;
            mode_reg    <= MODE_PASS;
        end
        else if (accept)
        begin
            if (first)
            begin
                ratio_reg <= status.ratio;
                mode_reg  <= status.mode;
            end
            if (final_frame)
            begin
                src_cnt_reg <= '0;
                out_cnt_reg <= '0;
                phase_reg   <= '0;
            end
            else
            begin
                src_cnt_reg <= src_cnt_reg + 1'b1;
                phase_reg   <= active ? phase_adv : r_use;
                if (rep)
                begin
                    out_cnt_reg <= out_cnt_reg + INDEX_WIDTH'(2);
                end
                else if (!drop_it)
                begin
                    out_cnt_reg <= out_cnt_reg + 1'b1;
                end
            end
        end
    end

endmodule

// File: rtl/core/frd_fifo.sv
// ============================================================================
// frd_fifo
// Short register queue that decouples the front end from the back end.
// ============================================================================
module frd_fifo
    import frd_pkg::*;
#(
    parameter int WIDTH = 98
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic do_wr;
    logic do_rd;

    assign full  = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: rtl/core/frd_back.sv
// ============================================================================
// frd_back
// Turns queued requests into one or two results held in an output register.
// ============================================================================
module frd_back
    import frd_pkg::*;
#(
    parameter int INDEX_WIDTH = 32,
    parameter int ENTRY_W     = 2 * INDEX_WIDTH + TAG_W + 2
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_empty,
    input  logic [ENTRY_W-1:0]     q_data,
    output logic                   q_pop,
    output logic                   empty,
    input  logic                   pop,
    output logic [INDEX_WIDTH-1:0] source_index,
    output logic [INDEX_WIDTH-1:0] output_index,
    output logic [TAG_W-1:0]       tag_out,
    output logic                   run_last,
    output logic                   stream_end
);

    logic                   valid_reg;
    logic                   pend_reg;
    logic [INDEX_WIDTH-1:0] src_reg;
    logic [INDEX_WIDTH-1:0] oidx_reg;
    logic [TAG_W-1:0]       tag_reg;
    logic                   last_reg;
    logic                   end_reg;

    logic [INDEX_WIDTH-1:0] e_src;
    logic [INDEX_WIDTH-1:0] e_oidx;
    logic [TAG_W-1:0]       e_tag;
    logic                   e_fin;
    logic                   e_rep;
    logic                   load;

    assign {e_src, e_oidx, e_tag, e_fin, e_rep} = q_data;

    assign load  = !valid_reg || pop;
    assign q_pop = load && !pend_reg && !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else if (load)
        begin
            if (pend_reg)
            begin
                valid_reg <= 1'b1;
                pend_reg  <= 1'b0;
            end
            else
            begin
                valid_reg <= !q_empty;
                pend_reg  <= !q_empty && e_rep;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (pend_reg)
            begin
                // Second copy of a repeated frame.
                oidx_reg <= oidx_reg + 1'b1;
                last_reg <= 1'b1;
            end
            else if (!q_empty)
            begin
                src_reg  <= e_src;
                oidx_reg <= e_oidx;
                tag_reg  <= e_tag;
                end_reg  <= e_fin;
                last_reg <= !e_rep;
            end
        end
    end

    assign empty        = !valid_reg;
    assign source_index = src_reg;
    assign output_index = oidx_reg;
    assign tag_out      = tag_reg;
    assign run_last     = last_reg;
    assign stream_end   = end_reg;

endmodule

// File: rtl/core/frd_checker.sv
// ============================================================================
// frd_checker
// Port-level assertions for the frame rate converter, bound to the top level.
// ============================================================================
module frd_checker
    import frd_pkg::*;
#(
    parameter int INDEX_WIDTH = 32
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   cfg_we,
    input logic                   full,
    input logic                   empty,
    input logic                   pop,
    input logic [INDEX_WIDTH-1:0] source_index,
    input logic [INDEX_WIDTH-1:0] output_index,
    input logic [TAG_W-1:0]       tag_out,
    input logic                   run_last,
    input logic                   stream_end
);

    // A register write always starts a setup pass that blocks new requests.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> full)
    else $error("full not raised after a register write");

    // The second copy of a repeated frame follows at once with the same frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !run_last) |=>
            (!empty && source_index == $past(source_index)
             && tag_out == $past(tag_out) && stream_end == $past(stream_end)))
    else $error("repeated frame copy missing or altered");

    // Copies of a repeated frame get consecutive output numbers.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !run_last) |=>
            (output_index == $past(output_index) + 1'b1 && run_last))
    else $error("output numbering broken within a repeated frame");

    // A waiting result holds until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(output_index) && $stable(tag_out)))
    else $error("waiting result changed before it was taken");

endmodule

bind frame_rate_drop_repeat frd_checker #(.INDEX_WIDTH(INDEX_WIDTH)) u_frd_checker (.*);

// File: bench/frame_rate_drop_repeat_tb.sv
// ----------------------------------------------------------------------------
// frame_rate_drop_repeat_tb
// Self-checking bench for the drop/repeat frame rate converter. Source frame
// requests go in through the push/full queue port and output frames come back
// through the empty/pop port. An in-bench model of the converter predicts
// every output frame, and each popped frame is compared field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frame_rate_drop_repeat_tb;
    import frd_pkg::*;

    localparam int IDX_W = 32;

    // Clock period 20 ns; the global limit covers several times the slowest run.
    localparam int TIMEOUT_NS = 20_000_000;
    // Cycles to let pass once nothing is expected, so that a request that
    // gives no output frame has surely left the pipeline.
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT = 20_000;
    localparam int PRESSURE_HOLD = 300;
    localparam int RANDOM_FRAMES = 1250;

    // The index port has one unused code; writes to it must be ignored.
    localparam cfg_index_t REG_UNUSED = 2'd3;

    // One output frame as seen on the result ports.
    typedef struct packed {
        logic [IDX_W-1:0] source_index;
        logic [IDX_W-1:0] output_index;
        logic [TAG_W-1:0] tag;
        logic             run_last;
        logic             stream_end;
    } out_frame_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    cfg_index_t            cfg_index = REG_SOURCE_RATE;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  push = 1'b0;
    logic                  full;
    logic [TAG_W-1:0]      frame_tag = '0;
    logic                  final_frame = 1'b0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [IDX_W-1:0]      source_index;
    logic [IDX_W-1:0]      output_index;
    logic [TAG_W-1:0]      tag_out;
    logic                  run_last;
    logic                  stream_end;

    frame_rate_drop_repeat #(
        .INDEX_WIDTH (IDX_W)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .push         (push),
        .full         (full),
        .frame_tag    (frame_tag),
        .final_frame  (final_frame),
        .empty        (empty),
        .pop          (pop),
        .source_index (source_index),
        .output_index (output_index),
        .tag_out      (tag_out),
        .run_last     (run_last),
        .stream_end   (stream_end)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // Converter model. The register mirror changes at once on a write;
    // the mode and the step ratio are only latched at the first frame of
    // a stream, exactly as the block does.
    // ------------------------------------------------------------------
    logic [SRC_W-1:0]   mirror_source_rate = SRC_RESET;
    logic [TGT_W-1:0]   mirror_target_rate = TGT_RESET;
    logic [PREC_W-1:0]  mirror_precision = PREC_RESET;
    mode_t              conv_mode = MODE_PASS;
    logic [RATIO_W-1:0] conv_step_ratio = '0;
    logic [RATIO_W-1:0] conv_phase = '0;
    logic [IDX_W-1:0]   conv_source_count = '0;
    logic [IDX_W-1:0]   conv_output_count = '0;

    out_frame_t pending_frames[$];
    int mismatch_count = 0;

    // Knobs shared between the stimulus and the receiver process.
    bit sender_gaps_on = 1'b1;
    bit receiver_gaps_on = 1'b1;
    bit pressure_request = 1'b0;
    int random_sent = 0;

    // Computes the mode and step ratio from the current register values.
    task automatic latch_step_ratio();
        logic [63:0] src;
        logic [63:0] tgt;
        logic [63:0] diff;
        logic [63:0] prod;
        src = 64'(mirror_source_rate);
        tgt = 64'(mirror_target_rate);
        diff = (tgt > src) ? (tgt - src) : (src - tgt);
        if (diff == 0)
        begin
            // Equal rates skip the division altogether.
            conv_mode = MODE_PASS;
            conv_step_ratio = '0;
        end
        else
        begin
            prod = src * 64'(mirror_precision);
            conv_step_ratio = RATIO_W'(prod / diff);
            if (conv_step_ratio == 0)
                conv_mode = MODE_PASS;
            else if (tgt < src)
                conv_mode = MODE_DROP;
            else
                conv_mode = MODE_REPEAT;
        end
    endtask

    task automatic queue_output_frame(input logic [TAG_W-1:0] tag, input logic last,
                                      input logic fin);
        out_frame_t frame;
        frame.source_index = conv_source_count;
        frame.output_index = conv_output_count;
        frame.tag = tag;
        frame.run_last = last;
        frame.stream_end = fin;
        pending_frames.push_back(frame);
        conv_output_count = conv_output_count + 1'b1;
    endtask

    // Predicts the output frames caused by one accepted source frame.
    task automatic predict_output_frames(input logic [TAG_W-1:0] tag, input logic fin);
        logic [63:0] prec;
        logic [63:0] ratio;
        logic [63:0] rem;
        logic        marked;
        prec = 64'(mirror_precision);
        marked = 1'b0;
        if (conv_source_count == 0)
        begin
            latch_step_ratio();
            conv_phase = '0;
        end
        ratio = 64'(conv_step_ratio);
        rem = 64'(conv_phase);
        if (conv_mode != MODE_PASS && ratio != 0)
        begin
            // The frame is marked when its interval of prec sub-steps
            // reaches the next multiple of the step ratio.
            if (prec != 0)
                marked = (rem == 0) || (ratio - rem < prec);
            conv_phase = RATIO_W'((rem + (prec % ratio)) % ratio);
        end
        if (conv_mode == MODE_DROP)
        begin
            if (!marked)
                queue_output_frame(tag, 1'b1, fin);
        end
        else if (conv_mode == MODE_REPEAT && marked)
        begin
            queue_output_frame(tag, 1'b0, fin);
            queue_output_frame(tag, 1'b1, fin);
        end
        else
            queue_output_frame(tag, 1'b1, fin);
        if (fin)
        begin
            // The stream ends even when its final frame was dropped.
            conv_source_count = '0;
            conv_output_count = '0;
            conv_phase = '0;
        end
        else
            conv_source_count = conv_source_count + 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Checker. Outputs are sampled at the rising edge, so the values seen
    // here are the ones that were on the ports just before the edge.
    // ------------------------------------------------------------------
    task automatic compare_field(input string name, input logic [63:0] exp_val,
                                 input logic [63:0] act_val);
        if (exp_val !== act_val)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name,
                     exp_val, act_val);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin : check_output_frame
        out_frame_t exp_frame;
        if (rst_n && pop && !empty)
        begin
            if (pending_frames.size() == 0)
            begin
                $display("%0t: unexpected output frame, expected none, actual src %0d out %0d",
                         $time, source_index, output_index);
                mismatch_count++;
            end
            else
            begin
                exp_frame = pending_frames.pop_front();
                compare_field("source_index", 64'(exp_frame.source_index), 64'(source_index));
                compare_field("output_index", 64'(exp_frame.output_index), 64'(output_index));
                compare_field("tag_out", 64'(exp_frame.tag), 64'(tag_out));
                compare_field("run_last", 64'(exp_frame.run_last), 64'(run_last));
                compare_field("stream_end", 64'(exp_frame.stream_end), 64'(stream_end));
            end
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Receiver: pop changes at the falling edge only, once per edge. The long
    // hold-off asked by the pressure test is counted here, in this process.
    int stall_left = 0;

    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pressure_request)
            begin
                pressure_request = 1'b0;
                stall_left = PRESSURE_HOLD;
            end
            else if (stall_left == 0 && receiver_gaps_on && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else
                pop <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------

    // Offers one request and holds it until the block takes it. The next
    // call raises push again at the next falling edge without lowering it.
    task automatic send_frame(input logic [TAG_W-1:0] tag, input logic fin);
        @(negedge clk);
        push <= 1'b1;
        frame_tag <= tag;
        final_frame <= fin;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_output_frames(tag, fin);
    endtask

    task automatic idle_sender(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            push <= 1'b0;
            frame_tag <= $urandom();
            final_frame <= 1'($urandom_range(0, 1));
        end
    endtask

    // Waits until every predicted frame has been popped, then lets the
    // pipeline settle so that dropped requests are also gone.
    task automatic wait_for_drain();
        int waited;
        waited = 0;
        @(negedge clk);
        push <= 1'b0;
        while (pending_frames.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_frames.size() != 0)
        begin
            $display("%0t: drain timed out, expected 0 pending frames, actual %0d",
                     $time, pending_frames.size());
            mismatch_count++;
        end
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Register write; callers make sure the block is idle first.
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SOURCE_RATE: mirror_source_rate = value[SRC_W-1:0];
            REG_TARGET_RATE: mirror_target_rate = value[TGT_W-1:0];
            REG_PRECISION:   mirror_precision = value[PREC_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_rates(input logic [CFG_DATA_W-1:0] src, input logic [CFG_DATA_W-1:0] tgt,
                             input logic [CFG_DATA_W-1:0] prec);
        wait_for_drain();
        write_reg(REG_SOURCE_RATE, src);
        write_reg(REG_TARGET_RATE, tgt);
        write_reg(REG_PRECISION, prec);
    endtask

    // ------------------------------------------------------------------
    // Directed tests.
    // ------------------------------------------------------------------

    // Reset rates are equal, so every frame passes once; tags at both ends.
    task automatic test_reset_passthrough();
        send_frame(32'h0000_0000, 1'b0);
        send_frame(32'hFFFF_FFFF, 1'b0);
        send_frame(32'h5A5A_A5A5, 1'b1);
    endtask

    // Slowing 30 to 25 fps drops one frame in six, starting with frame zero.
    // A stream made of one final frame is dropped whole and still ends.
    task automatic test_drop_mode();
        int i;
        set_rates(27'd30000, 27'd25000, 27'd1000);
        send_frame(32'hDEAD_0001, 1'b1);
        for (i = 0; i < 7; i++)
            send_frame($urandom(), i == 6);
    endtask

    // Doubling the rate repeats every frame.
    task automatic test_repeat_mode();
        set_rates(27'd25000, 27'd50000, 27'd1000);
        send_frame(32'hFFFF_FFFF, 1'b0);
        send_frame(32'h0000_0000, 1'b0);
        send_frame(32'h1234_5678, 1'b1);
    endtask

    // Ratios that come out as zero, zero precision, and equal rates at the
    // widest source rate and precision all fall back to plain pass-through.
    task automatic test_degenerate_ratios();
        set_rates(27'd0, 27'd25000, 27'd1000);
        send_frame($urandom(), 1'b1);
        set_rates(27'd30000, 27'd25000, 27'd0);
        send_frame($urandom(), 1'b1);
        set_rates(27'd1000, 27'd480000, 27'd1);
        send_frame($urandom(), 1'b1);
        set_rates(27'((1 << SRC_W) - 1), 27'((1 << SRC_W) - 1), 27'((1 << PREC_W) - 1));
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
        send_frame($urandom(), 1'b1);
    endtask

    // A write in the middle of a stream only takes effect at the next stream.
    task automatic test_midstream_write();
        set_rates(27'd30000, 27'd25000, 27'd1000);
        send_frame($urandom(), 1'b0);
        send_frame($urandom(), 1'b0);
        send_frame($urandom(), 1'b0);
        wait_for_drain();
        write_reg(REG_TARGET_RATE, 27'd50000);
        send_frame($urandom(), 1'b0);
        send_frame($urandom(), 1'b0);
        send_frame($urandom(), 1'b1);
        send_frame($urandom(), 1'b0);
        send_frame($urandom(), 1'b1);
    endtask

    // The receiver holds off for a long stretch while requests keep coming,
    // so the block fills up and must hold full high.
    task automatic test_backpressure();
        int i;
        set_rates(27'd25000, 27'd50000, 27'd1000);
        sender_gaps_on = 1'b0;
        @(posedge clk);
        pressure_request = 1'b1;
        for (i = 0; i < 24; i++)
            send_frame($urandom(), i == 23);
        sender_gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Random traffic.
    // ------------------------------------------------------------------
    function automatic logic [CFG_DATA_W-1:0] pick_source_rate();
        case ($urandom_range(0, 9))
            0: return 27'd1000;
            1: return 27'd240000;
            2: return 27'((1 << SRC_W) - 1);
            3: return CFG_DATA_W'($urandom());
            default: return CFG_DATA_W'($urandom_range(1000, 240000));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_target_rate(input logic [SRC_W-1:0] src);
        case ($urandom_range(0, 11))
            0: return 27'd1000;
            1: return 27'd480000;
            2: return 27'((1 << TGT_W) - 1);
            3: return 27'(src);
            4: return 27'(2 * src);
            5: return 27'(src + $urandom_range(1, 2000));
            6: return 27'((src * 3) / 4);
            7: return 27'((src * 5) / 4);
            8: return CFG_DATA_W'($urandom());
            default: return CFG_DATA_W'($urandom_range(1000, 480000));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_precision();
        logic [CFG_DATA_W-1:0] scale;
        int k;
        scale = 27'd1;
        case ($urandom_range(0, 9))
            0: return 27'd0;
            1: return 27'((1 << PREC_W) - 1);
            2: return CFG_DATA_W'($urandom());
            default:
            begin
                // Powers of ten from 1 up to 10^8.
                for (k = $urandom_range(0, 8); k > 0; k--)
                    scale = scale * 27'd10;
                return scale;
            end
        endcase
    endfunction

    task automatic run_random_phase();
        logic [CFG_DATA_W-1:0] src;
        int count;
        int fin_odds;
        int i;
        src = pick_source_rate();
        wait_for_drain();
        // Half the time a full new setting, otherwise a single register, which
        // may land in the middle of a stream.
        case ($urandom_range(0, 3))
            0: write_reg(REG_SOURCE_RATE, src);
            1: write_reg(REG_TARGET_RATE, pick_target_rate(mirror_source_rate));
            default:
            begin
                write_reg(REG_SOURCE_RATE, src);
                write_reg(REG_TARGET_RATE, pick_target_rate(src[SRC_W-1:0]));
                write_reg(REG_PRECISION, pick_precision());
            end
        endcase
        count = $urandom_range(20, 80);
        fin_odds = ($urandom_range(0, 3) == 0) ? 4 : 40;
        sender_gaps_on = ($urandom_range(0, 3) != 0);
        receiver_gaps_on = ($urandom_range(0, 3) != 0);
        for (i = 0; i < count; i++)
        begin
            if (sender_gaps_on)
                idle_sender(pick_gap());
            send_frame($urandom(), $urandom_range(1, fin_odds) == 1);
            random_sent++;
        end
    endtask

    task automatic test_random_traffic();
        while (random_sent < RANDOM_FRAMES)
            run_random_phase();
        sender_gaps_on = 1'b1;
        receiver_gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence. Reset is held from time zero and released at a
    // falling edge; the block then runs its setup pass with full high,
    // which the first request simply waits out.
    // ------------------------------------------------------------------
    initial
    begin
        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_passthrough();
        test_drop_mode();
        test_repeat_mode();
        test_degenerate_ratios();
        test_midstream_write();
        test_backpressure();
        test_random_traffic();

        wait_for_drain();
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Global limit on the run.
    initial
    begin
        #(TIMEOUT_NS);
        $display("%0t: run did not finish in time", $time);
        $display("Some tests failed");
        $finish;
    end

endmodule

// File: files.f
rtl/core/frd_pkg.sv
rtl/core/frd_div.sv
rtl/core/frd_setup.sv
rtl/core/frd_front.sv
rtl/core/frd_fifo.sv
rtl/core/frd_back.sv
rtl/core/frame_rate_drop_repeat.sv
rtl/core/frd_checker.sv
bench/frame_rate_drop_repeat_tb.sv
